/* rtl/bmp_pkg.sv */
`timescale 1ns / 1ps

package bmp_pkg;

  // Default sizes of the image and of the screen.
  localparam int MAX_WIDTH_DEF     = 2048;
  localparam int MAX_HEIGHT_DEF    = 2048;
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // Fixed field widths of the register file and of the result beat.
  localparam int DIM_W        = 12;
  localparam int ORIGIN_COL_W = 10;
  localparam int ORIGIN_ROW_W = 9;
  localparam int BYTE_W       = 8;
  localparam int COLOR_W      = 32;
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_WIDTH_NEGATIVE  = 3'd1,
    REG_IMAGE_HEIGHT    = 3'd2,
    REG_HEIGHT_NEGATIVE = 3'd3,
    REG_HAS_ALPHA       = 3'd4,
    REG_ORIGIN_COLUMN   = 3'd5,
    REG_ORIGIN_ROW      = 3'd6
  } reg_idx_t;

  // Position of the current byte within a pixel.
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_ALPHA = 2'd3
  } byte_phase_t;

  // Load strobes for the two registers of a wrap unit.
  typedef struct packed {
    logic load_q;
    logic load_r;
  } pipe_en_t;

endpackage

/* rtl/bmp_mod_wrap.sv */
`timescale 1ns / 1ps

module bmp_mod_wrap import bmp_pkg::*; #(
  parameter int VW      = 14,
  parameter int MODULUS = SCREEN_WIDTH_DEF,
  parameter int OW      = 10
) (
  input  logic          clk,
  input  pipe_en_t      en,
  input  logic [VW-1:0] value,
  output logic [OW-1:0] remainder
);

  // Reciprocal for an exact floor division of any VW-bit value.
  localparam int K  = VW + $clog2(MODULUS);
  localparam int MW = K + 1;
  localparam logic [MW-1:0] MUL = MW'(((64'd1 << K) + 64'(MODULUS) - 64'd1) / 64'(MODULUS));

  logic [VW+MW-1:0] prod;
  logic [VW-1:0]    q_nxt;
  logic [VW-1:0]    q_r;
  logic [VW-1:0]    v_r;
  logic [VW-1:0]    diff;
  logic [VW-1:0]    rem_nxt;
  logic [OW-1:0]    remainder_r;

  // Quotient estimate from the multiply by the reciprocal.
  always_comb begin
    prod  = (VW+MW)'(value) * (VW+MW)'(MUL);
    q_nxt = VW'(prod >> K);
  end

  always_ff @(posedge clk) begin
    if (en.load_q) begin
      q_r <= q_nxt;
      v_r <= value;
    end
  end

  // Remainder with one compare and subtract as a guard.
  always_comb begin
    diff = v_r - VW'(q_r * MODULUS);
    if (32'(diff) >= MODULUS) begin
      rem_nxt = diff - VW'(MODULUS);
    end else begin
      rem_nxt = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en.load_r) begin
      remainder_r <= OW'(rem_nxt);
    end
  end

  assign remainder = remainder_r;

endmodule

/* rtl/bmp_pixel_stream_to_screen.sv */
`timescale 1ns / 1ps

// Decodes the pixel array of a 24- or 32-bit BMP image, one byte per beat, and gives one
// result beat (screen column, screen row, ARGB color) for each finished pixel; padding
// bytes at the end of each row and all bytes after the last row give no result. The
// block takes one byte in every clock cycle for as long as the result side keeps up: the
// byte counters are registered as each byte is taken, and the result beat for the byte
// that finishes its pixel passes through a position stage and the two registered steps
// of the screen wraparound (multiply by a reciprocal, then remainder).
// Program the seven registers over the APB port before the first byte; only reset starts
// a new image.
module bmp_pixel_stream_to_screen import bmp_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  // Byte input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       in_pixel_byte,
  // Pixel results
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ORIGIN_COL_W-1:0] out_screen_column,
  output logic [ORIGIN_ROW_W-1:0] out_screen_row,
  output logic [COLOR_W-1:0]      out_argb_color
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int CVW = $clog2(MAX_WIDTH + (1 << ORIGIN_COL_W));
  localparam int RVW = $clog2(MAX_HEIGHT + (1 << ORIGIN_ROW_W));

  // Configuration registers.
  logic [DIM_W-1:0]        image_width_r;
  logic                    width_negative_r;
  logic [DIM_W-1:0]        image_height_r;
  logic                    height_negative_r;
  logic                    has_alpha_r;
  logic [ORIGIN_COL_W-1:0] origin_column_r;
  logic [ORIGIN_ROW_W-1:0] origin_row_r;
  logic                    cfg_wr;

  // Decoder state.
  byte_phase_t phase_r, phase_nxt;
  logic [23:0]   partial_r, partial_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic          done_r, done_nxt;

  // Working values of the byte stage.
  logic [CW-1:0]  w;
  logic [RW-1:0]  h;
  logic [CW-1:0]  x;
  logic [CW-1:0]  x_inc;
  logic [RW-1:0]  y_inc;
  logic [7:0]     alpha;
  logic           emit;
  logic [CVW-1:0] col_val;
  logic [RVW-1:0] row_val;
  logic [23:0]    rgb;

  // Pipeline registers and handshake.
  logic                 v1_r, v2_r, out_valid_r;
  logic [CVW-1:0]       col1_r;
  logic [RVW-1:0]       row1_r;
  logic [COLOR_W-1:0]   color1_r, color2_r, color3_r;
  logic                 rdy1, rdy2, rdy3;
  logic                 in_acc;
  pipe_en_t             wrap_en;

  // APB register file; reads return the stored value.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= '0;
      width_negative_r  <= 1'b0;
      image_height_r    <= '0;
      height_negative_r <= 1'b0;
      has_alpha_r       <= 1'b0;
      origin_column_r   <= '0;
      origin_row_r      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_IMAGE_WIDTH:     image_width_r     <= pwdata[DIM_W-1:0];
        REG_WIDTH_NEGATIVE:  width_negative_r  <= pwdata[0];
        REG_IMAGE_HEIGHT:    image_height_r    <= pwdata[DIM_W-1:0];
        REG_HEIGHT_NEGATIVE: height_negative_r <= pwdata[0];
        REG_HAS_ALPHA:       has_alpha_r       <= pwdata[0];
        REG_ORIGIN_COLUMN:   origin_column_r   <= pwdata[ORIGIN_COL_W-1:0];
        REG_ORIGIN_ROW:      origin_row_r      <= pwdata[ORIGIN_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_IMAGE_WIDTH:     prdata = APB_DW'(image_width_r);
      REG_WIDTH_NEGATIVE:  prdata = APB_DW'(width_negative_r);
      REG_IMAGE_HEIGHT:    prdata = APB_DW'(image_height_r);
      REG_HEIGHT_NEGATIVE: prdata = APB_DW'(height_negative_r);
      REG_HAS_ALPHA:       prdata = APB_DW'(has_alpha_r);
      REG_ORIGIN_COLUMN:   prdata = APB_DW'(origin_column_r);
      REG_ORIGIN_ROW:      prdata = APB_DW'(origin_row_r);
      default:             prdata = '0;
    endcase
  end

  // Stage ready chain: each stage moves when the one after it is free.
  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;

  // Image size, saturated to the supported maximum.
  always_comb begin
    w = (32'(image_width_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(image_width_r);
    h = (32'(image_height_r) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(image_height_r);
  end

  // Byte stage: walk the pixel, column, row and padding counters.
  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    done_nxt    = done_r;
    emit        = 1'b0;
    alpha       = 8'd0;
    rgb         = partial_r;
    x           = (col_r >= w) ? (w - CW'(1)) : col_r;
    x_inc       = x + CW'(1);
    y_inc       = row_r + RW'(1);
    if (in_acc && !done_r && (w != '0) && (h != '0)) begin
      if (row_r >= h) begin
        done_nxt = 1'b1;
      end else if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        case (phase_r)
          PH_BLUE: begin
            partial_nxt[7:0] = partial_r[7:0] | in_pixel_byte;
            phase_nxt        = PH_GREEN;
          end
          PH_GREEN: begin
            partial_nxt[15:8] = partial_r[15:8] | in_pixel_byte;
            phase_nxt         = PH_RED;
          end
          PH_RED: begin
            partial_nxt[23:16] = in_pixel_byte;
            rgb                = {in_pixel_byte, partial_r[15:0]};
            if (has_alpha_r) begin
              phase_nxt = PH_ALPHA;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            alpha = in_pixel_byte;
            emit  = 1'b1;
          end
        endcase
        if (emit) begin
          phase_nxt   = PH_BLUE;
          partial_nxt = '0;
          if (x_inc >= w) begin
            col_nxt = '0;
            pad_nxt = has_alpha_r ? 2'd0 : 2'(w);
            row_nxt = y_inc;
            if (y_inc >= h) begin
              done_nxt = 1'b1;
            end
          end else begin
            col_nxt = x_inc;
          end
        end
      end
    end
  end

  // Unwrapped screen position of the finished pixel.
  always_comb begin
    if (width_negative_r) begin
      col_val = CVW'(w) - CVW'(1) - CVW'(x) + CVW'(origin_column_r);
    end else begin
      col_val = CVW'(x) + CVW'(origin_column_r);
    end
    if (height_negative_r) begin
      row_val = RVW'(row_r) + RVW'(origin_row_r);
    end else begin
      row_val = RVW'(h) - RVW'(1) - RVW'(row_r) + RVW'(origin_row_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BLUE;
      partial_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      pad_r     <= '0;
      done_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
      done_r    <= done_nxt;
    end
  end

  // Valid bits of the three result stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_acc && emit;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Payload of the result stages.
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      col1_r   <= col_val;
      row1_r   <= row_val;
      color1_r <= {alpha, rgb};
    end
    if (wrap_en.load_q) begin
      color2_r <= color1_r;
    end
    if (wrap_en.load_r) begin
      color3_r <= color2_r;
    end
  end

  assign wrap_en.load_q = rdy2 && v1_r;
  assign wrap_en.load_r = rdy3 && v2_r;

  // Wraparound to the screen size.
  bmp_mod_wrap #(
    .VW      (CVW),
    .MODULUS (SCREEN_WIDTH),
    .OW      (ORIGIN_COL_W)
  ) u_wrap_col (
    .clk       (clk),
    .en        (wrap_en),
    .value     (col1_r),
    .remainder (out_screen_column)
  );

  bmp_mod_wrap #(
    .VW      (RVW),
    .MODULUS (SCREEN_HEIGHT),
    .OW      (ORIGIN_ROW_W)
  ) u_wrap_row (
    .clk       (clk),
    .en        (wrap_en),
    .value     (row1_r),
    .remainder (out_screen_row)
  );

  assign out_valid      = out_valid_r;
  assign out_argb_color = color3_r;

endmodule
